[rtl/core/fbm_pkg.sv]
// ---------------------------------------------------------------------------
// fbm_pkg
// Shared constants, CSR codes and reset values for the fractal value noise unit.
// ---------------------------------------------------------------------------
package fbm_pkg;

   localparam int OCTAVES_MAX_DEF = 8;
   localparam int COORD_FRAC_DEF  = 16;

   localparam int COORD_W     = 32;
   localparam int NOISE_W     = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int FREQ_W      = 32;
   localparam int AMP_W       = 32;
   localparam int LANE_W      = 57;   // signed corner blend times amplitude

   // register stages inside one octave lane and inside the divider
   localparam int LANE_STAGES = 11;
   localparam int DIV_STAGES  = 18;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SEED         = 2'd0,
      CSR_OCTAVE_COUNT = 2'd1,
      CSR_LACUNARITY   = 2'd2,
      CSR_GAIN         = 2'd3
   } csr_index_type;

   localparam logic [31:0] SEED_RST         = 32'd0;
   localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd1;
   localparam logic [15:0] LACUNARITY_RST   = 16'd8192;
   localparam logic [15:0] GAIN_RST         = 16'd8192;

   localparam logic [31:0] FREQ_START = 32'd4096;
   localparam logic [31:0] AMP_START  = 32'd16384;

   localparam logic [31:0] HASH_KX = 32'h9e3779b9;
   localparam logic [31:0] HASH_KY = 32'h85ebca6b;
   localparam logic [31:0] HASH_KZ = 32'hc2b2ae35;
   localparam logic [31:0] HASH_M1 = 32'h7feb352d;
   localparam logic [31:0] HASH_M2 = 32'h846ca68b;

endpackage

[rtl/core/fbm_value_noise_3d_unit.sv]
// ---------------------------------------------------------------------------
// fbm_value_noise_3d_unit
// Fractal value noise over a 3D lattice, summed over up to OCTAVES_MAX octaves.
//
// Request channel (req_*): one Q16.16 point per item, valid/ready.
// Response channel (rsp_*): one Q1.15 noise sample per item, same order.
// CSR port (csr_*): seed, octave count, lacunarity, gain; write when idle.
// Throughput: one item per cycle when not stalled or rebuilding; every octave
// has its own lane. Pipeline: 11 lane stages, adder tree ($clog2(OCTAVES_MAX),
// min 1 level) and 18 divider stages.
// After reset and after every CSR write the octave table is rebuilt, req_ready low.
// When rsp_ready is low with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module fbm_value_noise_3d_unit #(
   parameter int OCTAVES_MAX     = fbm_pkg::OCTAVES_MAX_DEF,
   parameter int COORD_FRAC_BITS = fbm_pkg::COORD_FRAC_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fbm_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [fbm_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [fbm_pkg::COORD_W-1:0] req_coord_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fbm_pkg::NOISE_W-1:0] rsp_noise_value,
   input  logic                               csr_write_en,
   input  logic [fbm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fbm_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import fbm_pkg::*;

   localparam int LV     = (OCTAVES_MAX > 1) ? $clog2(OCTAVES_MAX) : 1;
   localparam int LEAVES = 1 << LV;
   localparam int NORM_W = 32 + LV;
   localparam int SUM_W  = LANE_W + LV;
   localparam int LAT    = LANE_STAGES + LV + DIV_STAGES;

   logic              en;
   logic              accept;
   logic              busy;
   logic [31:0]       seed;
   logic [FREQ_W-1:0] freq_tab [OCTAVES_MAX];
   logic [AMP_W-1:0]  amp_tab  [OCTAVES_MAX];
   logic [NORM_W-1:0] norm;
   logic [LAT-1:0]    vld_ff;
   logic signed [SUM_W-1:0] node [LV+1][LEAVES];

   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en && !busy;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   fbm_tab #(
      .OCTAVES_MAX (OCTAVES_MAX),
      .NORM_W      (NORM_W)
   ) u_tab (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .seed           (seed),
      .freq_tab       (freq_tab),
      .amp_tab        (amp_tab),
      .norm           (norm),
      .busy           (busy)
   );

   for (genvar k = 0; k < LEAVES; k++) begin : g_lane
      if (k < OCTAVES_MAX) begin : g_used
         logic signed [LANE_W-1:0] lane_value;
         fbm_lane #(
            .COORD_FRAC_BITS (COORD_FRAC_BITS)
         ) u_lane (
            .clock   (clock),
            .en      (en),
            .coord_x (req_coord_x),
            .coord_y (req_coord_y),
            .coord_z (req_coord_z),
            .freq    (freq_tab[k]),
            .amp     (amp_tab[k]),
            .seed    (seed),
            .value   (lane_value)
         );
         assign node[0][k] = SUM_W'(lane_value);
      end else begin : g_pad
         assign node[0][k] = '0;
      end
   end

   // registered adder tree across octave lanes
   for (genvar l = 1; l <= LV; l++) begin : g_lvl
      for (genvar j = 0; j < LEAVES; j++) begin : g_node
         if (j < (LEAVES >> l)) begin : g_add
            logic signed [SUM_W-1:0] sum_ff;
            always_ff @(posedge clock) begin
               if (en) begin
                  sum_ff <= node[l-1][2*j] + node[l-1][2*j+1];
               end
            end
            assign node[l][j] = sum_ff;
         end else begin : g_zero
            assign node[l][j] = '0;
         end
      end
   end

   fbm_div #(
      .SUM_W  (SUM_W),
      .NORM_W (NORM_W)
   ) u_div (
      .clock (clock),
      .en    (en),
      .total (node[LV][0]),
      .norm  (norm),
      .noise (rsp_noise_value)
   );

endmodule

[rtl/core/fbm_tab.sv]
// ---------------------------------------------------------------------------
// fbm_tab
// CSR file plus per-octave frequency / amplitude table builder.
// ---------------------------------------------------------------------------
module fbm_tab #(
   parameter int OCTAVES_MAX = fbm_pkg::OCTAVES_MAX_DEF,
   parameter int NORM_W      = 33
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [fbm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fbm_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output logic [31:0]                      seed,
   output logic [fbm_pkg::FREQ_W-1:0]       freq_tab [OCTAVES_MAX],
   output logic [fbm_pkg::AMP_W-1:0]        amp_tab  [OCTAVES_MAX],
   output logic [NORM_W-1:0]                norm,
   output logic                             busy
);
   import fbm_pkg::*;

   localparam int KW = (OCTAVES_MAX > 1) ? $clog2(OCTAVES_MAX) : 1;

   logic [31:0]       seed_ff;
   logic [3:0]        octave_count_ff;
   logic [15:0]       lacunarity_ff;
   logic [15:0]       gain_ff;
   logic              busy_ff;
   logic [KW-1:0]     step_ff;
   logic [FREQ_W-1:0] freq_run_ff;
   logic [AMP_W-1:0]  amp_run_ff;
   logic [NORM_W-1:0] norm_ff;
   logic [FREQ_W-1:0] freq_tab_ff [OCTAVES_MAX];
   logic [AMP_W-1:0]  amp_tab_ff  [OCTAVES_MAX];

   logic [4:0]        oct_n;
   logic [47:0]       freq_prod;
   logic [47:0]       amp_prod;
   logic [FREQ_W-1:0] freq_in;
   logic [AMP_W-1:0]  amp_in;
   logic [AMP_W-1:0]  amp_used;

   always_comb begin
      oct_n = ({1'b0, octave_count_ff} > 5'(OCTAVES_MAX)) ? 5'(OCTAVES_MAX)
                                                         : {1'b0, octave_count_ff};
      freq_prod = 48'(freq_run_ff) * 48'(lacunarity_ff);
      amp_prod  = 48'(amp_run_ff) * 48'(gain_ff);
      freq_in   = (|freq_prod[47:44]) ? '1 : freq_prod[43:12];
      amp_in    = (|amp_prod[47:46]) ? '1 : amp_prod[45:14];
      // octaves past the count get zero weight
      amp_used  = (5'(step_ff) < oct_n) ? amp_run_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= SEED_RST;
         octave_count_ff <= OCTAVE_COUNT_RST;
         lacunarity_ff   <= LACUNARITY_RST;
         gain_ff         <= GAIN_RST;
         busy_ff         <= 1'b1;
         step_ff         <= '0;
         freq_run_ff     <= FREQ_START;
         amp_run_ff      <= AMP_START;
         norm_ff         <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_SEED:         seed_ff         <= csr_write_data[31:0];
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_write_data[3:0];
            CSR_LACUNARITY:   lacunarity_ff   <= csr_write_data[15:0];
            CSR_GAIN:         gain_ff         <= csr_write_data[15:0];
            default:          seed_ff         <= seed_ff;
         endcase
         busy_ff     <= 1'b1;
         step_ff     <= '0;
         freq_run_ff <= FREQ_START;
         amp_run_ff  <= AMP_START;
         norm_ff     <= '0;
      end else if (busy_ff) begin
         freq_tab_ff[step_ff] <= freq_run_ff;
         amp_tab_ff[step_ff]  <= amp_used;
         norm_ff              <= norm_ff + NORM_W'(amp_used);
         freq_run_ff          <= freq_in;
         amp_run_ff           <= amp_in;
         step_ff              <= step_ff + 1'b1;
         if (step_ff == KW'(OCTAVES_MAX - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign seed     = seed_ff;
   assign freq_tab = freq_tab_ff;
   assign amp_tab  = amp_tab_ff;
   assign norm     = norm_ff;
   assign busy     = busy_ff;

endmodule

[rtl/core/fbm_lane.sv]
// ---------------------------------------------------------------------------
// fbm_lane
// One octave: lattice split, corner hashing, quintic fade, trilinear blend,
// amplitude weighting. Eleven register stages, all advanced by en.
// ---------------------------------------------------------------------------
module fbm_lane #(
   parameter int COORD_FRAC_BITS = fbm_pkg::COORD_FRAC_DEF
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [fbm_pkg::COORD_W-1:0] coord_x,
   input  logic signed [fbm_pkg::COORD_W-1:0] coord_y,
   input  logic signed [fbm_pkg::COORD_W-1:0] coord_z,
   input  logic [fbm_pkg::FREQ_W-1:0]       freq,
   input  logic [fbm_pkg::AMP_W-1:0]        amp,
   input  logic [31:0]                      seed,
   output logic signed [fbm_pkg::LANE_W-1:0] value
);
   import fbm_pkg::*;

   localparam int F  = COORD_FRAC_BITS;
   localparam int PW = (44 + F > 65) ? 44 + F : 65;

   // stage 1
   logic signed [PW-1:0] p_ff [3];
   // stage 2
   logic [31:0] h1_ff [2];
   logic [31:0] y0_ff, z0_ff, z0_3_ff;
   logic [15:0] t_ff [3];
   logic [31:0] tsq_ff [3];
   logic [35:0] tlin_ff [3];
   // stage 3
   logic [31:0] h2_ff [4];
   logic [31:0] t3p_ff [3];
   logic [19:0] q_ff [3];
   // stage 4..7
   logic [31:0] hm_ff [8];
   logic [31:0] m1_ff [8];
   logic [31:0] m2_ff [8];
   logic signed [23:0] val_ff [8];
   logic [16:0] f4_ff [3], f5_ff [3], f6_ff [3], f7_ff [3];
   // blend stages
   logic signed [42:0] px_ff [4];
   logic signed [23:0] ax_ff [4];
   logic [16:0] fy8_ff, fz8_ff, fz9_ff;
   logic signed [42:0] py_ff [2];
   logic signed [23:0] ay_ff [2];
   logic signed [42:0] pz_ff;
   logic signed [23:0] az_ff;
   logic signed [LANE_W-1:0] value_ff;

   logic signed [PW-1:0] p_in [3];
   logic [31:0]          ip [3];
   logic [15:0]          t_in [3];
   logic [F+15:0]        t_ext [3];
   logic [31:0]          h1_in [2];
   logic [31:0]          h2_in [4];
   logic [31:0]          hm_in [8];
   logic [31:0]          m1_in [8];
   logic [31:0]          m2_in [8];
   logic signed [23:0]   val_in [8];
   logic [31:0]          t3p_in [3];
   logic [19:0]          q_in [3];
   logic [16:0]          f_in [3];
   logic [19:0]          coef [3];
   logic [36:0]          neg_sum [3];
   logic [35:0]          f_prod [3];
   logic signed [42:0]   px_in [4];
   logic signed [23:0]   bx [4];
   logic signed [42:0]   py_in [2];
   logic signed [23:0]   by [2];
   logic signed [42:0]   pz_in;
   logic signed [23:0]   vz;
   logic signed [LANE_W-1:0] value_in;

   always_comb begin
      logic [31:0] h;
      logic [31:0] c;
      logic [31:0] g;
      p_in[0] = PW'(coord_x) * $signed(PW'({1'b0, freq}));
      p_in[1] = PW'(coord_y) * $signed(PW'({1'b0, freq}));
      p_in[2] = PW'(coord_z) * $signed(PW'({1'b0, freq}));

      for (int i = 0; i < 3; i++) begin
         ip[i]    = p_ff[i][12+F+31:12+F];
         t_ext[i] = {p_ff[i][12+F-1:12], 16'd0};
         t_in[i]  = t_ext[i][F+15:F];
         coef[i]  = 20'd983040 - 20'(t_in[i] * 19'd6);
         neg_sum[i] = 37'(tlin_ff[i]) + 37'd65535;
         q_in[i]    = 20'd655360 - neg_sum[i][35:16];
         t3p_in[i]  = 32'(tsq_ff[i][31:16]) * 32'(t_ff[i]);
         f_prod[i]  = 36'(t3p_ff[i][31:16]) * 36'(q_ff[i]);
         f_in[i]    = (f_prod[i][35:16] > 20'd65536) ? 17'd65536 : f_prod[i][32:16];
      end

      for (int i = 0; i < 2; i++) begin
         c = ip[0] + 32'(i);
         h1_in[i] = seed ^ (HASH_KX + c + (seed << 6) + (seed >> 2));
      end
      for (int j = 0; j < 4; j++) begin
         h = h1_ff[j % 2];
         c = y0_ff + 32'(j / 2);
         h2_in[j] = h ^ (HASH_KY + c + (h << 6) + (h >> 2));
      end
      for (int j = 0; j < 8; j++) begin
         h = h2_ff[j % 4];
         c = z0_3_ff + 32'(j / 4);
         g = h ^ (HASH_KZ + c + (h << 6) + (h >> 2));
         hm_in[j] = g ^ (g >> 16);
         m1_in[j] = hm_ff[j] * HASH_M1;
         g = m1_ff[j] ^ (m1_ff[j] >> 15);
         m2_in[j] = g * HASH_M2;
         g = m2_ff[j] ^ (m2_ff[j] >> 16);
         // low 24 bits minus 2^23
         val_in[j] = {~g[23], g[22:0]};
      end

      for (int j = 0; j < 4; j++) begin
         px_in[j] = 43'(25'(val_ff[2*j+1]) - 25'(val_ff[2*j])) * $signed(43'({1'b0, f7_ff[0]}));
         bx[j]    = ax_ff[j] + px_ff[j][39:16];
      end
      for (int j = 0; j < 2; j++) begin
         py_in[j] = 43'(25'(bx[2*j+1]) - 25'(bx[2*j])) * $signed(43'({1'b0, fy8_ff}));
         by[j]    = ay_ff[j] + py_ff[j][39:16];
      end
      pz_in    = 43'(25'(by[1]) - 25'(by[0])) * $signed(43'({1'b0, fz9_ff}));
      vz       = az_ff + pz_ff[39:16];
      value_in = LANE_W'(vz) * $signed(LANE_W'({1'b0, amp}));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= p_in;
         h1_ff   <= h1_in;
         y0_ff   <= ip[1];
         z0_ff   <= ip[2];
         t_ff    <= t_in;
         for (int i = 0; i < 3; i++) begin
            tsq_ff[i]  <= 32'(t_in[i]) * 32'(t_in[i]);
            tlin_ff[i] <= 36'(t_in[i]) * 36'(coef[i]);
         end
         h2_ff   <= h2_in;
         z0_3_ff <= z0_ff;
         t3p_ff  <= t3p_in;
         q_ff    <= q_in;
         hm_ff   <= hm_in;
         f4_ff   <= f_in;
         m1_ff   <= m1_in;
         f5_ff   <= f4_ff;
         m2_ff   <= m2_in;
         f6_ff   <= f5_ff;
         val_ff  <= val_in;
         f7_ff   <= f6_ff;
         px_ff   <= px_in;
         for (int j = 0; j < 4; j++) begin
            ax_ff[j] <= val_ff[2*j];
         end
         fy8_ff  <= f7_ff[1];
         fz8_ff  <= f7_ff[2];
         py_ff   <= py_in;
         ay_ff[0] <= bx[0];
         ay_ff[1] <= bx[2];
         fz9_ff  <= fz8_ff;
         pz_ff   <= pz_in;
         az_ff   <= by[0];
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

[rtl/core/fbm_div.sv]
// ---------------------------------------------------------------------------
// fbm_div
// Normalizing divide: floor(total / (norm * 2^8)) saturated to Q1.15.
// Restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module fbm_div #(
   parameter int SUM_W  = 60,
   parameter int NORM_W = 33
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [SUM_W-1:0]           total,
   input  logic [NORM_W-1:0]                 norm,
   output logic signed [fbm_pkg::NOISE_W-1:0] noise
);
   import fbm_pkg::*;

   localparam int CW = ((SUM_W > NORM_W + 24) ? SUM_W : NORM_W + 24) + 1;
   localparam int QB = NOISE_W;

   logic [CW-1:0]  d;
   logic           neg_a_ff;
   logic [CW-1:0]  mag_ff;
   logic [CW-1:0]  rem_ff [QB];
   logic [QB-1:0]  q_ff   [QB];
   logic           neg_ff [QB];
   logic           ovf_ff [QB];
   logic signed [NOISE_W-1:0] noise_ff;

   logic [NOISE_W:0]          up;
   logic signed [NOISE_W-1:0] noise_in;

   assign d = CW'({norm, 8'd0});

   always_ff @(posedge clock) begin
      if (en) begin
         neg_a_ff <= total[SUM_W-1];
         mag_ff   <= total[SUM_W-1] ? CW'(-total) : CW'(total);
      end
   end

   for (genvar i = 0; i < QB; i++) begin : g_bit
      localparam int B = QB - 1 - i;
      logic [CW-1:0] rem_prev;
      logic [QB-1:0] q_prev;
      logic          neg_prev;
      logic          ovf_prev;
      logic [CW-1:0] dsh;
      if (i == 0) begin : g_first
         assign rem_prev = mag_ff;
         assign q_prev   = '0;
         assign neg_prev = neg_a_ff;
         // quotient would need more than QB bits
         assign ovf_prev = (mag_ff >= (d << QB));
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign q_prev   = q_ff[i-1];
         assign neg_prev = neg_ff[i-1];
         assign ovf_prev = ovf_ff[i-1];
      end
      assign dsh = d << B;
      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i] <= neg_prev;
            ovf_ff[i] <= ovf_prev;
            if (rem_prev >= dsh) begin
               rem_ff[i] <= rem_prev - dsh;
               q_ff[i]   <= q_prev | (QB'(1) << B);
            end else begin
               rem_ff[i] <= rem_prev;
               q_ff[i]   <= q_prev;
            end
         end
      end
   end

   always_comb begin
      up = {1'b0, q_ff[QB-1]} + (NOISE_W+1)'(rem_ff[QB-1] != '0);
      if (norm == '0) begin
         noise_in = '0;
      end else if (!neg_ff[QB-1]) begin
         noise_in = (ovf_ff[QB-1] || q_ff[QB-1][QB-1]) ? {1'b0, {(NOISE_W-1){1'b1}}}
                                                       : q_ff[QB-1];
      end else begin
         // negative totals round toward minus infinity
         noise_in = (ovf_ff[QB-1] || up > {2'b01, {(NOISE_W-1){1'b0}}})
                    ? {1'b1, {(NOISE_W-1){1'b0}}} : NOISE_W'(-up);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         noise_ff <= noise_in;
      end
   end

   assign noise = noise_ff;

endmodule
